[hw/rtl/dual_motor_ramp_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// Dual motor ramp sequencer assertion macros
// Shared property shorthands for the sequencer checks.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_RAMP_SEQUENCER_MACROS_SVH
`define DUAL_MOTOR_RAMP_SEQUENCER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define DMRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define DMRS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dmrs_pkg.sv]
// ----------------------------------------------------------------------------
// dmrs_pkg
// Types, codes and constants of the dual motor ramp sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dmrs_pkg;

	localparam int unsigned POWER_W = 7;
	localparam int unsigned DUTY_W  = 8;
	localparam int unsigned WAIT_W  = 7;

	localparam logic [2:0] MODE_TICK     = 3'd0;
	localparam logic [2:0] MODE_STOP     = 3'd1;
	localparam logic [2:0] MODE_LEFT     = 3'd2;
	localparam logic [2:0] MODE_RIGHT    = 3'd3;
	localparam logic [2:0] MODE_FORWARD  = 3'd4;
	localparam logic [2:0] MODE_BACKWARD = 3'd5;
	localparam logic [2:0] MODE_SHUFFLE  = 3'd6;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_STOP    = 3'd1;
	localparam logic [2:0] PH_TURN    = 3'd2;
	localparam logic [2:0] PH_ACCEL   = 3'd3;
	localparam logic [2:0] PH_SHUFFLE = 3'd4;
	localparam logic [2:0] PH_HOLD    = 3'd5;

	localparam logic [2:0] REG_PWM_PERIOD   = 3'd0;
	localparam logic [2:0] REG_LEFT_LIMIT   = 3'd1;
	localparam logic [2:0] REG_RIGHT_LIMIT  = 3'd2;
	localparam logic [2:0] REG_FORWARD_MAX  = 3'd3;
	localparam logic [2:0] REG_BACKWARD_MAX = 3'd4;

	localparam logic [DUTY_W-1:0]  PWM_PERIOD_RST = 8'd199;
	localparam logic [POWER_W-1:0] TURN_LIMIT_RST = 7'd25;
	localparam logic [POWER_W-1:0] POWER_MAX      = 7'd100;

	localparam logic [WAIT_W-1:0] STOP_WAIT    = 7'd10;
	localparam logic [WAIT_W-1:0] TURN_WAIT    = 7'd3;
	localparam logic [WAIT_W-1:0] TURN_HOLD    = 7'd30;
	localparam logic [WAIT_W-1:0] ACCEL_WAIT   = 7'd10;
	localparam logic [WAIT_W-1:0] SHUFFLE_WAIT = 7'd7;
	localparam logic [WAIT_W-1:0] SHUFFLE_HOLD = 7'd100;

	localparam logic [POWER_W-1:0] SHUFFLE_FWD_TARGET = 7'd15;
	localparam logic [POWER_W-1:0] SHUFFLE_BWD_TARGET = 7'd40;

	// floor(x/100) = (x*5243) >> 19 for x below 43690
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int unsigned DIV100_SHIFT = 19;

	typedef struct packed {
		logic [DUTY_W-1:0]  pwm_period;
		logic [POWER_W-1:0] left_turn_limit;
		logic [POWER_W-1:0] right_turn_limit;
		logic [POWER_W-1:0] forward_max_power;
		logic [POWER_W-1:0] backward_max_power;
	} cfg_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  pwm_period;
		logic [POWER_W-1:0] left_power;
		logic [POWER_W-1:0] right_power;
		logic               left_forward;
		logic               right_forward;
		logic               brake_on;
		logic               busy_res;
		logic               rejected;
	} stage_t;

	function automatic logic [POWER_W-1:0] clamp_power(input logic [POWER_W-1:0] v);
		return (v > POWER_MAX) ? POWER_MAX : v;
	endfunction

	function automatic logic [POWER_W-1:0] sat_add(input logic [POWER_W-1:0] p,
		input logic [1:0] inc);
		logic [POWER_W:0] sum;
		sum = {1'b0, p} + {{(POWER_W-1){1'b0}}, inc};
		return (sum > {1'b0, POWER_MAX}) ? POWER_MAX : sum[POWER_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/dual_motor_ramp_sequencer.sv]
// A taken item is registered in stage 1, then stage 2, then the output register.
// Throughput: one item per cycle; the pipeline stalls only while a result waits unread.
// The limit per item is the duty path: power*period, then a reciprocal multiply by 1/100.
// Reset (arst_n low, asynchronous): powers 0, directions reverse, sequencer idle,
// registers back to period 199, turn limits 25, maximum powers 100; pipeline empty.
// ----------------------------------------------------------------------------
// dual_motor_ramp_sequencer
// Two-motor power ramp sequencer driven by ticks and commands.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_motor_ramp_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // mode[2:0], shuffle_forward[3], zero[7:4]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // left_duty[7:0], right_duty[15:8],
	                                    // left_direction[16], right_direction[17],
	                                    // brake_on[18], busy_res[19], rejected[20],
	                                    // zero[23:21]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	dmrs_pkg::cfg_t   cfg_q;
	dmrs_pkg::stage_t stage_s1;

	logic                        en, accept, v_s1, v_s2, v_q;
	logic [4:0]                  flags_s2, flags_q;
	logic [dmrs_pkg::DUTY_W-1:0] ld_q, rd_q;

	assign cfg_ready = 1'b1;
	assign en        = !v_q || m_tready;
	assign s_tready  = en;
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = v_q;
	assign m_tdata   = {3'b000, flags_q, rd_q, ld_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_period         <= dmrs_pkg::PWM_PERIOD_RST;
			cfg_q.left_turn_limit    <= dmrs_pkg::TURN_LIMIT_RST;
			cfg_q.right_turn_limit   <= dmrs_pkg::TURN_LIMIT_RST;
			cfg_q.forward_max_power  <= dmrs_pkg::POWER_MAX;
			cfg_q.backward_max_power <= dmrs_pkg::POWER_MAX;
		end else if (cfg_valid) begin
			case (cfg_index)
				dmrs_pkg::REG_PWM_PERIOD:   cfg_q.pwm_period         <= cfg_data;
				dmrs_pkg::REG_LEFT_LIMIT:   cfg_q.left_turn_limit    <= cfg_data[6:0];
				dmrs_pkg::REG_RIGHT_LIMIT:  cfg_q.right_turn_limit   <= cfg_data[6:0];
				dmrs_pkg::REG_FORWARD_MAX:  cfg_q.forward_max_power  <= cfg_data[6:0];
				dmrs_pkg::REG_BACKWARD_MAX: cfg_q.backward_max_power <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_q  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s2 <= {stage_s1.rejected, stage_s1.busy_res, stage_s1.brake_on,
				stage_s1.right_forward, stage_s1.left_forward};
			flags_q  <= flags_s2;
		end
	end

	dmrs_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.mode            (s_tdata[2:0]),
		.shuffle_forward (s_tdata[3]),
		.cfg             (cfg_q),
		.stage_s1        (stage_s1)
	);

	dmrs_duty u_duty_left (
		.clk    (clk),
		.en     (en),
		.power  (stage_s1.left_power),
		.fwd    (stage_s1.left_forward),
		.period (stage_s1.pwm_period),
		.duty_q (ld_q)
	);

	dmrs_duty u_duty_right (
		.clk    (clk),
		.en     (en),
		.power  (stage_s1.right_power),
		.fwd    (stage_s1.right_forward),
		.period (stage_s1.pwm_period),
		.duty_q (rd_q)
	);

`include "dual_motor_ramp_sequencer_macros.svh"

	`DMRS_ASSERT_IMP(a_rej_busy, m_tvalid && m_tdata[20], m_tdata[19], "rejected while idle")
	`DMRS_ASSERT_IMP(a_brake_busy, m_tvalid && m_tdata[18], m_tdata[19], "brake while idle")
	`DMRS_ASSERT_IMP(a_power_max, v_s1,
		(stage_s1.left_power <= dmrs_pkg::POWER_MAX) &&
		(stage_s1.right_power <= dmrs_pkg::POWER_MAX), "power above 100")
	`DMRS_ASSERT_NXT(a_accept_s1, accept, v_s1, "accepted item lost before stage 1")

endmodule

`default_nettype wire

[hw/rtl/dmrs_ctrl.sv]
// ----------------------------------------------------------------------------
// dmrs_ctrl
// Sequencer state and one-item update; registers the post-item motor state.
// ----------------------------------------------------------------------------
`default_nettype none

module dmrs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic [2:0]     mode,
	input  wire logic           shuffle_forward,
	input  wire dmrs_pkg::cfg_t cfg,
	output dmrs_pkg::stage_t    stage_s1
);

	logic [dmrs_pkg::POWER_W-1:0] lp_q, rp_q, tgt_q;
	logic [dmrs_pkg::WAIT_W-1:0]  wc_q;
	logic                         lf_q, rf_q;
	logic [2:0]                   ph_q, cmd_q;

	logic [dmrs_pkg::POWER_W-1:0] n_lp, n_rp, n_tgt;
	logic [dmrs_pkg::WAIT_W-1:0]  n_wc;
	logic                         n_lf, n_rf;
	logic [2:0]                   n_ph, n_cmd;
	logic                         rej, do_step, is_cmd, busy, lo, ro, left_turn;

	assign is_cmd = (mode >= dmrs_pkg::MODE_STOP) && (mode <= dmrs_pkg::MODE_SHUFFLE);
	assign busy   = (ph_q != dmrs_pkg::PH_IDLE);

	always_comb begin
		n_lp    = lp_q;
		n_rp    = rp_q;
		n_tgt   = tgt_q;
		n_wc    = wc_q;
		n_lf    = lf_q;
		n_rf    = rf_q;
		n_ph    = ph_q;
		n_cmd   = cmd_q;
		rej     = 1'b0;
		do_step = 1'b0;
		lo      = 1'b0;
		ro      = 1'b0;

		if (is_cmd) begin
			if (busy) begin
				rej = 1'b1;
			end else begin
				n_cmd   = mode;
				do_step = 1'b1;
				case (mode)
					dmrs_pkg::MODE_STOP: begin
						n_ph = dmrs_pkg::PH_STOP;
					end
					dmrs_pkg::MODE_LEFT, dmrs_pkg::MODE_RIGHT: begin
						n_lf  = (mode == dmrs_pkg::MODE_RIGHT);
						n_rf  = (mode == dmrs_pkg::MODE_LEFT);
						n_tgt = dmrs_pkg::clamp_power((mode == dmrs_pkg::MODE_LEFT) ?
							cfg.right_turn_limit : cfg.left_turn_limit);
						n_ph  = dmrs_pkg::PH_TURN;
					end
					dmrs_pkg::MODE_FORWARD, dmrs_pkg::MODE_BACKWARD: begin
						n_lf = (mode == dmrs_pkg::MODE_FORWARD);
						n_rf = (mode == dmrs_pkg::MODE_FORWARD);
						if (lp_q > rp_q) begin
							n_rp = lp_q;
						end else begin
							n_lp = rp_q;
						end
						n_tgt = dmrs_pkg::clamp_power((mode == dmrs_pkg::MODE_FORWARD) ?
							cfg.forward_max_power : cfg.backward_max_power);
						n_ph  = dmrs_pkg::PH_ACCEL;
					end
					default: begin
						n_lf  = shuffle_forward;
						n_rf  = shuffle_forward;
						n_tgt = shuffle_forward ? dmrs_pkg::SHUFFLE_FWD_TARGET :
							dmrs_pkg::SHUFFLE_BWD_TARGET;
						n_ph  = dmrs_pkg::PH_SHUFFLE;
					end
				endcase
			end
		end else if (busy) begin
			if (wc_q != '0) begin
				n_wc = wc_q - 1'b1;
			end
			if (n_wc == '0) begin
				do_step = 1'b1;
				if (ph_q == dmrs_pkg::PH_HOLD) begin
					n_ph = dmrs_pkg::PH_STOP;
				end
			end
		end

		left_turn = (n_cmd == dmrs_pkg::MODE_LEFT);

		if (do_step) begin
			case (n_ph)
				dmrs_pkg::PH_STOP: begin
					if ((n_lp != '0) || (n_rp != '0)) begin
						if (n_lp != '0) n_lp = n_lp - 1'b1;
						if (n_rp != '0) n_rp = n_rp - 1'b1;
						n_wc = dmrs_pkg::STOP_WAIT;
					end else begin
						n_ph = dmrs_pkg::PH_IDLE;
						n_wc = '0;
					end
				end
				dmrs_pkg::PH_TURN: begin
					if ((left_turn ? n_rp : n_lp) < n_tgt) begin
						if (left_turn) begin
							n_lp = dmrs_pkg::sat_add(n_lp, 2'd2);
							n_rp = dmrs_pkg::sat_add(n_rp, 2'd1);
						end else begin
							n_rp = dmrs_pkg::sat_add(n_rp, 2'd2);
							n_lp = dmrs_pkg::sat_add(n_lp, 2'd1);
						end
						n_wc = dmrs_pkg::TURN_WAIT;
					end else begin
						n_ph = dmrs_pkg::PH_HOLD;
						n_wc = dmrs_pkg::TURN_HOLD;
					end
				end
				dmrs_pkg::PH_ACCEL, dmrs_pkg::PH_SHUFFLE: begin
					lo = (n_lp < n_tgt);
					ro = (n_rp < n_tgt);
					if (lo) n_lp = n_lp + 1'b1;
					if (ro) n_rp = n_rp + 1'b1;
					if (lo || ro) begin
						n_wc = (n_ph == dmrs_pkg::PH_ACCEL) ? dmrs_pkg::ACCEL_WAIT :
							dmrs_pkg::SHUFFLE_WAIT;
					end else if (n_ph == dmrs_pkg::PH_ACCEL) begin
						n_ph = dmrs_pkg::PH_IDLE;
						n_wc = '0;
					end else begin
						n_ph = dmrs_pkg::PH_HOLD;
						n_wc = dmrs_pkg::SHUFFLE_HOLD;
					end
				end
				default: begin
					n_ph = dmrs_pkg::PH_IDLE;
					n_wc = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q  <= '0;
			rp_q  <= '0;
			tgt_q <= '0;
			wc_q  <= '0;
			lf_q  <= 1'b0;
			rf_q  <= 1'b0;
			ph_q  <= dmrs_pkg::PH_IDLE;
			cmd_q <= dmrs_pkg::MODE_TICK;
		end else if (accept) begin
			lp_q  <= n_lp;
			rp_q  <= n_rp;
			tgt_q <= n_tgt;
			wc_q  <= n_wc;
			lf_q  <= n_lf;
			rf_q  <= n_rf;
			ph_q  <= n_ph;
			cmd_q <= n_cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.pwm_period    <= cfg.pwm_period;
			stage_s1.left_power    <= n_lp;
			stage_s1.right_power   <= n_rp;
			stage_s1.left_forward  <= n_lf;
			stage_s1.right_forward <= n_rf;
			stage_s1.brake_on      <= (n_ph == dmrs_pkg::PH_STOP);
			stage_s1.busy_res      <= (n_ph != dmrs_pkg::PH_IDLE);
			stage_s1.rejected      <= rej;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/dmrs_duty.sv]
// ----------------------------------------------------------------------------
// dmrs_duty
// Two-stage power to PWM duty: power*period/100, or period minus it if fwd.
// ----------------------------------------------------------------------------
`default_nettype none

module dmrs_duty (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [dmrs_pkg::POWER_W-1:0] power,
	input  wire logic                         fwd,
	input  wire logic [dmrs_pkg::DUTY_W-1:0]  period,
	output logic      [dmrs_pkg::DUTY_W-1:0]  duty_q
);

	localparam int unsigned PROD_W = dmrs_pkg::POWER_W + dmrs_pkg::DUTY_W;
	localparam int unsigned QMUL_W = PROD_W + 13;

	logic [PROD_W-1:0]           prod_s2;
	logic                        fwd_s2;
	logic [dmrs_pkg::DUTY_W-1:0] period_s2;
	logic [QMUL_W-1:0]           qmul;
	logic [dmrs_pkg::DUTY_W-1:0] quot;

	assign qmul = prod_s2 * dmrs_pkg::DIV100_MUL;
	assign quot = qmul[dmrs_pkg::DIV100_SHIFT +: dmrs_pkg::DUTY_W];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2   <= power * period;
			fwd_s2    <= fwd;
			period_s2 <= period;
			duty_q    <= fwd_s2 ? (period_s2 - quot) : quot;
		end
	end

endmodule

`default_nettype wire
